@@ sv/eqrm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eqrm_pkg
// Shared types, constants and the multiply-accumulate program for the
// Euler/quaternion to rotation matrix block.
// ----------------------------------------------------------------------------
package eqrm_pkg;

  localparam int CORDIC_STEPS_DEF    = 16;
  localparam int COMPONENT_WIDTH_DEF = 16;

  localparam int ANG_W        = 16;
  localparam int SC_W         = 18;
  localparam int PAIR_W       = 36;
  localparam int CZ_W         = 34;
  localparam int ATAN_ENTRIES = 24;
  localparam int ATAN_IDX_W   = 5;
  localparam int PC_W         = 5;
  localparam int QUAT_SHIFT   = 34;
  localparam int MAT_SHIFT    = 14;
  localparam int ANG_SHIFT    = 17;
  localparam int SC_SHIFT     = 14;

  localparam logic [PC_W-1:0] PC_EULER_START = 5'd0;
  localparam logic [PC_W-1:0] PC_MAT_START   = 5'd12;
  localparam logic [PC_W-1:0] PC_LAST        = 5'd29;

  localparam logic signed [CZ_W-1:0] CORDIC_K    = 34'sd652032874;
  localparam logic signed [CZ_W-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [CZ_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

  typedef enum logic [1:0] {
    CMD_LOAD_QUAT  = 2'd0,
    CMD_LOAD_EULER = 2'd1,
    CMD_REPORT     = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         column;
    logic signed [15:0] elem_row0;
    logic signed [15:0] elem_row1;
    logic signed [15:0] elem_row2;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic signed [15:0] out_w;
    logic               last;
  } out_beat_t;

  typedef enum logic [3:0] {
    A_P0, A_P1, A_P2, A_P3, A_CP, A_SP, A_QX, A_QY, A_QZ, A_QW
  } a_sel_t;

  typedef enum logic [2:0] {
    B_CY, B_SY, B_CR, B_SR, B_QX, B_QY, B_QZ, B_QW
  } b_sel_t;

  typedef enum logic [1:0] {
    K_PAIR, K_QUAT, K_MAT
  } kind_t;

  typedef struct packed {
    a_sel_t     a;
    b_sel_t     b;
    kind_t      kind;
    logic       first;
    logic       last;
    logic       sub;
    logic       dbl;
    logic       one;
    logic [3:0] dest;
  } mac_op_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [3:0] dest;
  } mac_wr_t;

  function automatic logic signed [CZ_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [CZ_W-1:0] r;
    unique case (idx)
      5'd0:    r = 34'sd843314856;
      5'd1:    r = 34'sd497837829;
      5'd2:    r = 34'sd263043836;
      5'd3:    r = 34'sd133525158;
      5'd4:    r = 34'sd67021686;
      5'd5:    r = 34'sd33543515;
      5'd6:    r = 34'sd16775850;
      5'd7:    r = 34'sd8388437;
      5'd8:    r = 34'sd4194282;
      5'd9:    r = 34'sd2097149;
      5'd10:   r = 34'sd1048575;
      5'd11:   r = 34'sd524287;
      5'd12:   r = 34'sd262143;
      5'd13:   r = 34'sd131071;
      5'd14:   r = 34'sd65535;
      5'd15:   r = 34'sd32767;
      5'd16:   r = 34'sd16383;
      5'd17:   r = 34'sd8191;
      5'd18:   r = 34'sd4095;
      5'd19:   r = 34'sd2047;
      5'd20:   r = 34'sd1023;
      5'd21:   r = 34'sd511;
      5'd22:   r = 34'sd255;
      5'd23:   r = 34'sd127;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic mac_op_t mk(input a_sel_t a, input b_sel_t b, input kind_t k,
                                 input logic first, input logic last, input logic sub,
                                 input logic dbl, input logic one, input logic [3:0] dest);
    mac_op_t r;
    r.a     = a;
    r.b     = b;
    r.kind  = k;
    r.first = first;
    r.last  = last;
    r.sub   = sub;
    r.dbl   = dbl;
    r.one   = one;
    r.dest  = dest;
    return r;
  endfunction

  // pair products, quaternion terms, then matrix entries in column-major order
  function automatic mac_op_t prog_op(input logic [PC_W-1:0] pc);
    mac_op_t r;
    unique case (pc)
      5'd0:    r = mk(A_CP, B_CY, K_PAIR, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0);
      5'd1:    r = mk(A_SP, B_SY, K_PAIR, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 4'd1);
      5'd2:    r = mk(A_SP, B_CY, K_PAIR, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 4'd2);
      5'd3:    r = mk(A_CP, B_SY, K_PAIR, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 4'd3);
      5'd4:    r = mk(A_P0, B_CR, K_QUAT, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 4'd3);
      5'd5:    r = mk(A_P1, B_SR, K_QUAT, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 4'd3);
      5'd6:    r = mk(A_P0, B_SR, K_QUAT, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0);
      5'd7:    r = mk(A_P1, B_CR, K_QUAT, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 4'd0);
      5'd8:    r = mk(A_P2, B_CR, K_QUAT, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 4'd1);
      5'd9:    r = mk(A_P3, B_SR, K_QUAT, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 4'd1);
      5'd10:   r = mk(A_P3, B_CR, K_QUAT, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 4'd2);
      5'd11:   r = mk(A_P2, B_SR, K_QUAT, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 4'd2);
      5'd12:   r = mk(A_QY, B_QY, K_MAT, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 4'd0);
      5'd13:   r = mk(A_QZ, B_QZ, K_MAT, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 4'd0);
      5'd14:   r = mk(A_QX, B_QY, K_MAT, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 4'd1);
      5'd15:   r = mk(A_QZ, B_QW, K_MAT, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 4'd1);
      5'd16:   r = mk(A_QX, B_QZ, K_MAT, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 4'd2);
      5'd17:   r = mk(A_QY, B_QW, K_MAT, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 4'd2);
      5'd18:   r = mk(A_QX, B_QY, K_MAT, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 4'd3);
      5'd19:   r = mk(A_QZ, B_QW, K_MAT, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 4'd3);
      5'd20:   r = mk(A_QX, B_QX, K_MAT, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 4'd4);
      5'd21:   r = mk(A_QZ, B_QZ, K_MAT, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 4'd4);
      5'd22:   r = mk(A_QY, B_QZ, K_MAT, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 4'd5);
      5'd23:   r = mk(A_QX, B_QW, K_MAT, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 4'd5);
      5'd24:   r = mk(A_QX, B_QZ, K_MAT, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 4'd6);
      5'd25:   r = mk(A_QY, B_QW, K_MAT, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 4'd6);
      5'd26:   r = mk(A_QY, B_QZ, K_MAT, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 4'd7);
      5'd27:   r = mk(A_QX, B_QW, K_MAT, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 4'd7);
      5'd28:   r = mk(A_QX, B_QX, K_MAT, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 4'd8);
      5'd29:   r = mk(A_QY, B_QY, K_MAT, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 4'd8);
      default: r = mk(A_P0, B_CY, K_PAIR, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0);
    endcase
    return r;
  endfunction

endpackage

@@ sv/eqrm_cordic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eqrm_cordic
// Rotation-mode CORDIC, one micro-rotation per cycle, giving sine and cosine
// of half a Q4.12 angle, rounded to Q16.
// ----------------------------------------------------------------------------
module eqrm_cordic #(
  parameter int STEPS = eqrm_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [eqrm_pkg::ANG_W-1:0] angle,
  output logic                              done,
  output logic signed [eqrm_pkg::SC_W-1:0]  sin_val,
  output logic signed [eqrm_pkg::SC_W-1:0]  cos_val
);

  localparam int CZ_W   = eqrm_pkg::CZ_W;
  localparam int STEP_W = $clog2(STEPS);

  typedef enum logic [2:0] {
    C_IDLE = 3'b001,
    C_ROT  = 3'b010,
    C_FIN  = 3'b100
  } cst_t;

  cst_t                   st;
  logic [STEP_W-1:0]      cnt;
  logic signed [CZ_W-1:0] x, y, z;
  logic                   flip;

  logic signed [CZ_W-1:0] z0, z0_fold, dx, dy, at, xr, yr;

  always_comb begin
    z0 = CZ_W'(angle) <<< eqrm_pkg::ANG_SHIFT;
    if (z0 > eqrm_pkg::HALF_PI_Q30) begin
      z0_fold = z0 - eqrm_pkg::PI_Q30;
    end else if (z0 < -eqrm_pkg::HALF_PI_Q30) begin
      z0_fold = z0 + eqrm_pkg::PI_Q30;
    end else begin
      z0_fold = z0;
    end
    dx = y >>> cnt;
    dy = x >>> cnt;
    at = eqrm_pkg::atan_q30(eqrm_pkg::ATAN_IDX_W'(cnt));
    xr = (x + CZ_W'(64'sd8192)) >>> eqrm_pkg::SC_SHIFT;
    yr = (y + CZ_W'(64'sd8192)) >>> eqrm_pkg::SC_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= C_IDLE;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= (st == C_FIN);
      unique case (st)
        C_IDLE: begin
          if (start) begin
            cnt <= '0;
            st  <= C_ROT;
          end
        end
        C_ROT: begin
          if (cnt == STEP_W'(STEPS - 1)) begin
            st <= C_FIN;
          end else begin
            cnt <= cnt + STEP_W'(1);
          end
        end
        C_FIN: begin
          st <= C_IDLE;
        end
        default: st <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st == C_IDLE && start) begin
      x    <= eqrm_pkg::CORDIC_K;
      y    <= '0;
      z    <= z0_fold;
      flip <= (z0 > eqrm_pkg::HALF_PI_Q30) || (z0 < -eqrm_pkg::HALF_PI_Q30);
    end else if (st == C_ROT) begin
      if (!z[CZ_W-1]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - at;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + at;
      end
    end
    if (st == C_FIN) begin
      cos_val <= flip ? -xr[eqrm_pkg::SC_W-1:0] : xr[eqrm_pkg::SC_W-1:0];
      sin_val <= flip ? -yr[eqrm_pkg::SC_W-1:0] : yr[eqrm_pkg::SC_W-1:0];
    end
  end

endmodule

@@ sv/eqrm_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eqrm_mac
// Shared multiplier with registered product and an accumulator that rounds
// and saturates the finished sum.
// ----------------------------------------------------------------------------
module eqrm_mac #(
  parameter int CW = eqrm_pkg::COMPONENT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                issue,
  input  eqrm_pkg::mac_op_t                   op,
  input  logic signed [((CW > eqrm_pkg::PAIR_W) ? CW : eqrm_pkg::PAIR_W)-1:0] a,
  input  logic signed [((CW > eqrm_pkg::SC_W) ? CW : eqrm_pkg::SC_W)-1:0]     b,
  output eqrm_pkg::mac_wr_t                   wr,
  output logic signed [CW-1:0]                res,
  output logic signed [eqrm_pkg::PAIR_W-1:0]  pair
);

  localparam int MA    = (CW > eqrm_pkg::PAIR_W) ? CW : eqrm_pkg::PAIR_W;
  localparam int MB    = (CW > eqrm_pkg::SC_W) ? CW : eqrm_pkg::SC_W;
  localparam int ACC_W = MA + MB + 3;

  localparam logic signed [ACC_W-1:0] QUAT_BIAS    = ACC_W'(64'sd8589934592);
  localparam logic signed [ACC_W-1:0] MAT_BIAS     = ACC_W'(64'sd8192);
  localparam logic signed [ACC_W-1:0] MAT_ONE_BIAS = ACC_W'(64'sd268443648);
  localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

  logic signed [MA+MB-1:0] prod;
  eqrm_pkg::mac_op_t       op_r;
  logic                    v_r;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] term, addend, init, base, sum, shifted;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_r <= 1'b0;
    end else begin
      v_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op;
    prod <= a * b;
    if (v_r) begin
      acc <= sum;
    end
  end

  always_comb begin
    term = ACC_W'(prod);
    if (op_r.dbl) begin
      term = term <<< 1;
    end
    addend = op_r.sub ? -term : term;
    if (op_r.kind == eqrm_pkg::K_QUAT) begin
      init = QUAT_BIAS;
    end else begin
      init = op_r.one ? MAT_ONE_BIAS : MAT_BIAS;
    end
    base = op_r.first ? init : acc;
    sum  = base + addend;
    if (op_r.kind == eqrm_pkg::K_QUAT) begin
      shifted = sum >>> eqrm_pkg::QUAT_SHIFT;
    end else begin
      shifted = sum >>> eqrm_pkg::MAT_SHIFT;
    end
    if (shifted > SAT_HI) begin
      res = SAT_HI[CW-1:0];
    end else if (shifted < SAT_LO) begin
      res = SAT_LO[CW-1:0];
    end else begin
      res = shifted[CW-1:0];
    end
    pair     = prod[eqrm_pkg::PAIR_W-1:0];
    wr.valid = v_r && op_r.last;
    wr.kind  = op_r.kind;
    wr.dest  = op_r.dest;
  end

endmodule

@@ sv/euler_quaternion_rotation_matrix.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_quaternion_rotation_matrix
// Holds an orientation quaternion, loads it directly or from ZYX Euler angles
// and emits the 3x3 rotation matrix one column per beat.
//
//   channel  dir  handshake            payload
//   in       in   in_valid/in_ready    eqrm_pkg::in_beat_t
//   out      out  out_valid/out_ready  eqrm_pkg::out_beat_t
//
// load-quaternion and report commands: run the matrix program, drain, then three beats
// euler command: first runs the half-angle CORDIC on yaw, pitch and roll in turn,
// then the pair and quaternion products, ahead of the matrix program
// all products go through one multiplier; in_ready is low until the last beat
// a stalled out beat holds the sequencer; reset restores the identity quaternion
// ----------------------------------------------------------------------------
module euler_quaternion_rotation_matrix #(
  parameter int CORDIC_STEPS    = eqrm_pkg::CORDIC_STEPS_DEF,
  parameter int COMPONENT_WIDTH = eqrm_pkg::COMPONENT_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  eqrm_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output eqrm_pkg::out_beat_t out_data
);

  localparam int CW = COMPONENT_WIDTH;
  localparam int MA = (CW > eqrm_pkg::PAIR_W) ? CW : eqrm_pkg::PAIR_W;
  localparam int MB = (CW > eqrm_pkg::SC_W) ? CW : eqrm_pkg::SC_W;

  localparam logic [1:0] ANG_YAW   = 2'd0;
  localparam logic [1:0] ANG_PITCH = 2'd1;
  localparam logic [1:0] ANG_ROLL  = 2'd2;
  localparam logic [1:0] COL_LAST  = 2'd2;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ANG   = 6'b000010,
    S_WAIT  = 6'b000100,
    S_RUN   = 6'b001000,
    S_DRAIN = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  function automatic logic signed [CW-1:0] sat16(input logic signed [15:0] v);
    logic signed [32:0] e, hi, lo;
    logic signed [CW-1:0] r;
    e  = 33'(v);
    hi = (33'sd1 <<< (CW - 1)) - 33'sd1;
    lo = -hi - 33'sd1;
    if (e > hi) begin
      r = hi[CW-1:0];
    end else if (e < lo) begin
      r = lo[CW-1:0];
    end else begin
      r = e[CW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] low16(input logic signed [CW-1:0] v);
    logic signed [CW+15:0] e;
    e = {{16{v[CW-1]}}, v};
    return e[15:0];
  endfunction

  state_t                   state;
  logic [eqrm_pkg::PC_W-1:0] pc;
  logic [1:0]               col;
  logic [1:0]               ang_idx;
  logic signed [CW-1:0]     q [0:3];

  eqrm_pkg::in_beat_t                 in_reg;
  logic signed [eqrm_pkg::SC_W-1:0]   s_ang [0:2];
  logic signed [eqrm_pkg::SC_W-1:0]   c_ang [0:2];
  logic signed [eqrm_pkg::PAIR_W-1:0] p [0:3];
  logic signed [CW-1:0]               m [0:8];

  logic                               cordic_start, cordic_done;
  logic signed [eqrm_pkg::ANG_W-1:0]  cordic_angle;
  logic signed [eqrm_pkg::SC_W-1:0]   cordic_sin, cordic_cos;

  eqrm_pkg::mac_op_t                  op;
  eqrm_pkg::mac_wr_t                  wr;
  logic signed [MA-1:0]               mac_a;
  logic signed [MB-1:0]               mac_b;
  logic signed [CW-1:0]               mac_res;
  logic signed [eqrm_pkg::PAIR_W-1:0] mac_pair;
  logic                               issue;

  assign in_ready     = (state == S_IDLE);
  assign out_valid    = (state == S_EMIT);
  assign cordic_start = (state == S_ANG);
  assign issue        = (state == S_RUN);

  always_comb begin
    unique case (ang_idx)
      ANG_YAW:   cordic_angle = in_reg.yaw;
      ANG_PITCH: cordic_angle = in_reg.pitch;
      ANG_ROLL:  cordic_angle = in_reg.roll;
      default:   cordic_angle = in_reg.roll;
    endcase
  end

  eqrm_cordic #(
    .STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cordic_start),
    .angle   (cordic_angle),
    .done    (cordic_done),
    .sin_val (cordic_sin),
    .cos_val (cordic_cos)
  );

  always_comb begin
    op = eqrm_pkg::prog_op(pc);
    unique case (op.a)
      eqrm_pkg::A_P0: mac_a = MA'(p[0]);
      eqrm_pkg::A_P1: mac_a = MA'(p[1]);
      eqrm_pkg::A_P2: mac_a = MA'(p[2]);
      eqrm_pkg::A_P3: mac_a = MA'(p[3]);
      eqrm_pkg::A_CP: mac_a = MA'(c_ang[1]);
      eqrm_pkg::A_SP: mac_a = MA'(s_ang[1]);
      eqrm_pkg::A_QX: mac_a = MA'(q[0]);
      eqrm_pkg::A_QY: mac_a = MA'(q[1]);
      eqrm_pkg::A_QZ: mac_a = MA'(q[2]);
      eqrm_pkg::A_QW: mac_a = MA'(q[3]);
      default:        mac_a = '0;
    endcase
    unique case (op.b)
      eqrm_pkg::B_CY: mac_b = MB'(c_ang[0]);
      eqrm_pkg::B_SY: mac_b = MB'(s_ang[0]);
      eqrm_pkg::B_CR: mac_b = MB'(c_ang[2]);
      eqrm_pkg::B_SR: mac_b = MB'(s_ang[2]);
      eqrm_pkg::B_QX: mac_b = MB'(q[0]);
      eqrm_pkg::B_QY: mac_b = MB'(q[1]);
      eqrm_pkg::B_QZ: mac_b = MB'(q[2]);
      eqrm_pkg::B_QW: mac_b = MB'(q[3]);
      default:        mac_b = '0;
    endcase
  end

  eqrm_mac #(
    .CW(CW)
  ) u_mac (
    .clk   (clk),
    .rst   (rst),
    .issue (issue),
    .op    (op),
    .a     (mac_a),
    .b     (mac_b),
    .wr    (wr),
    .res   (mac_res),
    .pair  (mac_pair)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pc      <= '0;
      col     <= '0;
      ang_idx <= ANG_YAW;
      q[0]    <= '0;
      q[1]    <= '0;
      q[2]    <= '0;
      q[3]    <= sat16(16'sd16384);
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            unique case (in_data.cmd)
              eqrm_pkg::CMD_LOAD_QUAT: begin
                q[0]  <= sat16(in_data.quat_x);
                q[1]  <= sat16(in_data.quat_y);
                q[2]  <= sat16(in_data.quat_z);
                q[3]  <= sat16(in_data.quat_w);
                pc    <= eqrm_pkg::PC_MAT_START;
                state <= S_RUN;
              end
              eqrm_pkg::CMD_LOAD_EULER: begin
                ang_idx <= ANG_YAW;
                state   <= S_ANG;
              end
              default: begin
                pc    <= eqrm_pkg::PC_MAT_START;
                state <= S_RUN;
              end
            endcase
          end
        end
        S_ANG: state <= S_WAIT;
        S_WAIT: begin
          if (cordic_done) begin
            if (ang_idx == ANG_ROLL) begin
              pc    <= eqrm_pkg::PC_EULER_START;
              state <= S_RUN;
            end else begin
              ang_idx <= ang_idx + 2'd1;
              state   <= S_ANG;
            end
          end
        end
        S_RUN: begin
          if (pc == eqrm_pkg::PC_LAST) begin
            state <= S_DRAIN;
          end else begin
            pc <= pc + eqrm_pkg::PC_W'(1);
          end
        end
        S_DRAIN: begin
          col   <= '0;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_ready) begin
            if (col == COL_LAST) begin
              state <= S_IDLE;
            end else begin
              col <= col + 2'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      if (wr.valid && wr.kind == eqrm_pkg::K_QUAT) begin
        q[wr.dest[1:0]] <= mac_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg <= in_data;
    end
    if (state == S_WAIT && cordic_done) begin
      s_ang[ang_idx] <= cordic_sin;
      c_ang[ang_idx] <= cordic_cos;
    end
    if (wr.valid && wr.kind == eqrm_pkg::K_PAIR) begin
      p[wr.dest[1:0]] <= mac_pair;
    end
    if (wr.valid && wr.kind == eqrm_pkg::K_MAT) begin
      m[wr.dest] <= mac_res;
    end
    // shift the next column into place after each beat
    if (out_valid && out_ready) begin
      m[0] <= m[3];
      m[1] <= m[4];
      m[2] <= m[5];
      m[3] <= m[6];
      m[4] <= m[7];
      m[5] <= m[8];
    end
  end

  always_comb begin
    out_data.column    = col;
    out_data.elem_row0 = low16(m[0]);
    out_data.elem_row1 = low16(m[1]);
    out_data.elem_row2 = low16(m[2]);
    out_data.out_x     = low16(q[0]);
    out_data.out_y     = low16(q[1]);
    out_data.out_z     = low16(q[2]);
    out_data.out_w     = low16(q[3]);
    out_data.last      = (col == COL_LAST);
  end

`ifndef NO_ASSERTIONS
  a_no_accept_while_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input ready while a column beat is pending");

  a_ready_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_data.last) |=> in_ready)
    else $error("block not ready after last column beat");

  a_cordic_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    cordic_done |-> (state == S_WAIT)) else $error("cordic result outside wait state");

  a_mac_write_in_run: assert property (@(posedge clk) disable iff (rst)
    wr.valid |-> (state == S_RUN || state == S_DRAIN))
    else $error("multiply-accumulate write outside run");
`endif

endmodule
